// ----- hw/rtl/sst_pkg.sv -----
package sst_pkg;

  localparam int unsigned NUM_SLOTS   = 64;
  localparam int unsigned STRIDE_BITS = 32;
  localparam int unsigned SLOT_AW     = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W       = $clog2(NUM_SLOTS + 1);

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned PRIO_W     = 16;
  localparam int unsigned QCOUNT_W   = 7;
  localparam int unsigned SLICE_W    = 8;
  localparam int unsigned DIVIDEND_W = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [SLICE_W-1:0]    MAX_SLICE_RESET  = SLICE_W'(5);
  localparam logic [DIVIDEND_W-1:0] PASS_NUMER_RESET = DIVIDEND_W'(1 << 10);

  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PICK    = 2'd2,
    OP_TICK    = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SLICE  = 2'd0,
    CFG_PASS_NUMER = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_SCAN,
    S_PRIO,
    S_DIV_GO,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hw/rtl/sst_if.sv -----
interface sst_req_if import sst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SLOT_W-1:0]   slot;
  logic [PRIO_W-1:0]   priority_req;

  modport source(output valid, opcode, slot, priority_req, input ready);
  modport sink(input valid, opcode, slot, priority_req, output ready);
endinterface

interface sst_rsp_if import sst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                picked_valid;
  logic [SLOT_W-1:0]   picked_slot;
  logic                resched_req;
  logic                error;
  logic [QCOUNT_W-1:0] queued_count;

  modport source(output valid, picked_valid, picked_slot, resched_req, error, queued_count,
                 input ready);
  modport sink(input valid, picked_valid, picked_slot, resched_req, error, queued_count,
               output ready);
endinterface

interface sst_cfg_if import sst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/sst_ram.sv -----
module sst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/sst_div.sv -----
module sst_div import sst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [PRIO_W-1:0]     divisor,
  output div_rsp_t              rsp
);

  localparam int unsigned DIV_CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [PRIO_W-1:0]     rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [PRIO_W-1:0]     dvs;
  logic                  dvs_zero;
  logic [PRIO_W:0]       trial;
  logic                  fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem, quo[DIVIDEND_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= DIV_CNT_W'(DIVIDEND_W);
      rem      <= '0;
      quo      <= dividend;
      dvs      <= divisor;
      dvs_zero <= divisor == '0;
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
      if (fits) begin
        rem <= PRIO_W'(trial - {1'b0, dvs});
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= PRIO_W'(trial);
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  // a zero priority gives no stride growth
  assign rsp.done     = done;
  assign rsp.quotient = dvs_zero ? '0 : quo;

endmodule

// ----- hw/rtl/stride_scheduler_table.sv -----
// enqueue, dequeue and tick are decoded in S_OP; the result is registered once the output is free
// pick: time is set by the scan through the stride RAM read port and the bit-serial divider
// one item at a time: a new input is taken only after the previous result has been loaded
// reset: synchronous rst clears queued flags, task count and the stride and slice valid
//   bits at once (no clearing pass); max_slice returns to 5 and pass_numer to 1024
module stride_scheduler_table import sst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sst_req_if.sink    req,
  sst_rsp_if.source  rsp,
  sst_cfg_if.sink    cfg
);

  localparam int unsigned SCAN_W = SLOT_AW + 1;
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(NUM_SLOTS);

  typedef struct packed {
    logic                picked_valid;
    logic [SLOT_W-1:0]   picked_slot;
    logic                resched_req;
    logic                error;
    logic [QCOUNT_W-1:0] queued_count;
  } res_t;

  state_t state, state_next;

  opcode_t              op_q;
  logic [SLOT_AW-1:0]   slot_q;
  logic [PRIO_W-1:0]    prio_q;
  logic                 in_range_q;

  logic [NUM_SLOTS-1:0] queued;
  logic [NUM_SLOTS-1:0] stride_ok;
  logic [NUM_SLOTS-1:0] slice_ok;
  logic [CNT_W-1:0]     task_count;
  logic [CNT_W-1:0]     task_count_next;

  logic [SLICE_W-1:0]    max_slice;
  logic [DIVIDEND_W-1:0] pass_numer;

  logic                   slice_re, slice_we;
  logic [SLOT_AW-1:0]     slice_raddr;
  logic [SLICE_W-1:0]     slice_wdata, slice_rd, slice_cur;
  logic                   slice_ok_q;

  logic                   prio_re, prio_we;
  logic [PRIO_W-1:0]      prio_rd;

  logic                   stride_re, stride_we;
  logic [SLOT_AW-1:0]     stride_raddr;
  logic [STRIDE_BITS-1:0] stride_wdata, stride_rd, stride_cand, stride_diff;
  logic                   stride_ok_q;

  logic [SCAN_W-1:0]      scan_cnt;
  logic                   cmp_live;
  logic [SLOT_AW-1:0]     cmp_idx;
  logic                   found;
  logic                   take;
  logic [SLOT_AW-1:0]     best_idx;
  logic [STRIDE_BITS-1:0] best_stride;

  logic     div_start;
  div_rsp_t div_rsp;

  logic accept;
  logic out_free;
  logic res_load;
  logic rsp_valid;
  res_t res_next, res_q;
  logic q_set, q_clr;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp_valid || rsp.ready;
  assign cfg.ready = 1'b1;

  assign slice_cur   = slice_ok_q ? slice_rd : '0;
  assign stride_cand = stride_ok_q ? stride_rd : '0;
  // wrap-aware order: candidate is smaller when the difference has its top bit set
  assign stride_diff = stride_cand - best_stride;
  assign take        = cmp_live && queued[cmp_idx] && (!found || stride_diff[STRIDE_BITS-1]);

  sst_ram #(.WIDTH(SLICE_W), .DEPTH(NUM_SLOTS)) u_slice_ram (
    .clk   (clk),
    .we    (slice_we),
    .waddr (slot_q),
    .wdata (slice_wdata),
    .re    (slice_re),
    .raddr (slice_raddr),
    .rdata (slice_rd)
  );

  sst_ram #(.WIDTH(PRIO_W), .DEPTH(NUM_SLOTS)) u_prio_ram (
    .clk   (clk),
    .we    (prio_we),
    .waddr (slot_q),
    .wdata (prio_q),
    .re    (prio_re),
    .raddr (best_idx),
    .rdata (prio_rd)
  );

  sst_ram #(.WIDTH(STRIDE_BITS), .DEPTH(NUM_SLOTS)) u_stride_ram (
    .clk   (clk),
    .we    (stride_we),
    .waddr (best_idx),
    .wdata (stride_wdata),
    .re    (stride_re),
    .raddr (stride_raddr),
    .rdata (stride_rd)
  );

  sst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pass_numer),
    .divisor  (prio_rd),
    .rsp      (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_OP;
      end
      S_OP: begin
        if (op_q == OP_PICK) state_next = S_SCAN;
        else if (out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (cmp_live && scan_cnt == SCAN_END) state_next = S_PRIO;
      end
      S_PRIO: begin
        if (found) state_next = S_DIV_GO;
        else if (out_free) state_next = S_IDLE;
      end
      S_DIV_GO: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready       = 1'b0;
    slice_re        = 1'b0;
    slice_raddr     = SLOT_AW'(req.slot);
    slice_we        = 1'b0;
    slice_wdata     = slice_cur;
    prio_we         = 1'b0;
    prio_re         = 1'b0;
    stride_re       = 1'b0;
    stride_raddr    = scan_cnt[SLOT_AW-1:0];
    stride_we       = 1'b0;
    stride_wdata    = best_stride + STRIDE_BITS'(div_rsp.quotient);
    div_start       = 1'b0;
    res_load        = 1'b0;
    q_set           = 1'b0;
    q_clr           = 1'b0;
    task_count_next = task_count;
    res_next        = '0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        slice_re  = accept;
      end
      S_OP: begin
        unique case (op_q)
          OP_ENQUEUE: begin
            if (!in_range_q || prio_q == '0 || queued[slot_q]) begin
              res_next.error = 1'b1;
            end else begin
              prio_we         = out_free;
              slice_we        = out_free;
              q_set           = out_free;
              task_count_next = task_count + CNT_W'(1);
              if (slice_cur == '0 || slice_cur > max_slice) slice_wdata = max_slice;
            end
          end
          OP_DEQUEUE: begin
            if (!in_range_q || !queued[slot_q]) begin
              res_next.error = 1'b1;
            end else begin
              q_clr           = out_free;
              task_count_next = task_count - CNT_W'(1);
            end
          end
          OP_TICK: begin
            if (!in_range_q) begin
              res_next.error = 1'b1;
            end else begin
              slice_we = out_free;
              if (slice_cur != '0) slice_wdata = slice_cur - SLICE_W'(1);
              res_next.resched_req = slice_wdata == '0;
            end
          end
          OP_PICK: begin
          end
          default: begin
          end
        endcase
        res_load = (op_q != OP_PICK) && out_free;
      end
      S_SCAN: begin
        stride_re = scan_cnt != SCAN_END;
      end
      S_PRIO: begin
        prio_re  = found;
        res_load = !found && out_free;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
      end
      S_DIV: begin
      end
      S_FIN: begin
        stride_we             = out_free;
        res_load              = out_free;
        res_next.picked_valid = 1'b1;
        res_next.picked_slot  = SLOT_W'(best_idx);
      end
      default: begin
      end
    endcase
    res_next.queued_count = QCOUNT_W'(task_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      queued     <= '0;
      stride_ok  <= '0;
      slice_ok   <= '0;
      task_count <= '0;
      max_slice  <= MAX_SLICE_RESET;
      pass_numer <= PASS_NUMER_RESET;
      rsp_valid  <= 1'b0;
      cmp_live   <= 1'b0;
      found      <= 1'b0;
    end else begin
      state      <= state_next;
      task_count <= res_load ? task_count_next : task_count;
      cmp_live   <= stride_re;
      if (q_set) queued[slot_q] <= 1'b1;
      if (q_clr) queued[slot_q] <= 1'b0;
      if (slice_we) slice_ok[slot_q] <= 1'b1;
      if (stride_we) stride_ok[best_idx] <= 1'b1;
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (accept) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MAX_SLICE:  max_slice  <= SLICE_W'(cfg.data);
          CFG_PASS_NUMER: pass_numer <= DIVIDEND_W'(cfg.data);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= opcode_t'(req.opcode);
      slot_q     <= SLOT_AW'(req.slot);
      prio_q     <= req.priority_req;
      in_range_q <= 32'(req.slot) < NUM_SLOTS;
      scan_cnt   <= '0;
    end else if (stride_re) begin
      scan_cnt <= scan_cnt + SCAN_W'(1);
    end
    if (slice_re) slice_ok_q <= slice_ok[slice_raddr];
    if (stride_re) begin
      stride_ok_q <= stride_ok[stride_raddr];
      cmp_idx     <= stride_raddr;
    end
    if (take) begin
      best_idx    <= cmp_idx;
      best_stride <= stride_cand;
    end
    if (res_load) res_q <= res_next;
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.picked_valid = res_q.picked_valid;
  assign rsp.picked_slot  = res_q.picked_slot;
  assign rsp.resched_req  = res_q.resched_req;
  assign rsp.error        = res_q.error;
  assign rsp.queued_count = res_q.queued_count;

`ifndef ASSERT_OFF
  a_count_matches_flags: assert property (@(posedge clk) disable iff (rst)
    task_count == CNT_W'($countones(queued)))
    else $error("task count differs from number of queued slots");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  a_stride_write_queued: assert property (@(posedge clk) disable iff (rst)
    stride_we |-> queued[best_idx])
    else $error("stride advanced on a slot that is not queued");

  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    res_load |=> rsp.valid)
    else $error("finished result not presented");
`endif

endmodule

// ----- tb/tb_stride_scheduler_table.sv -----
module tb_stride_scheduler_table import sst_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PICK_LATENCY   = 120;
  localparam int RANDOM_PER_PHASE = 365;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                picked_valid;
    logic [SLOT_W-1:0]   picked_slot;
    logic                resched_req;
    logic                error;
    logic [QCOUNT_W-1:0] queued_count;
  } sched_outcome_t;

  typedef struct packed {
    opcode_t           op;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
    logic              typed;
    sched_outcome_t    outcome;
  } probe_row_t;

  logic clk;
  logic rst;

  sst_req_if req_ch ();
  sst_rsp_if rsp_ch ();
  sst_cfg_if cfg_ch ();

  stride_scheduler_table DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // scheduler image kept in step with accepted transfers
  logic                   slot_queued [NUM_SLOTS];
  logic [STRIDE_BITS-1:0] slot_stride [NUM_SLOTS];
  logic [PRIO_W-1:0]      slot_prio   [NUM_SLOTS];
  logic [SLICE_W-1:0]     slot_slice  [NUM_SLOTS];
  logic [QCOUNT_W-1:0]    queued_total;
  logic [SLICE_W-1:0]     cur_max_slice;
  logic [DIVIDEND_W-1:0]  cur_pass_numer;

  sched_outcome_t pending_outcomes [$];
  probe_row_t     directed_rows [$];

  int mismatch_count;
  int req_idle_pct;
  int rsp_stall_pct;
  int rsp_hold_left;
  int stall_cycles;

  sched_outcome_t seen_outcome;
  sched_outcome_t want_outcome;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic sched_outcome_t outcome_of(logic pv, logic [SLOT_W-1:0] ps, logic nr,
                                                logic er, logic [QCOUNT_W-1:0] qc);
    sched_outcome_t res;
    res.picked_valid = pv;
    res.picked_slot  = ps;
    res.resched_req  = nr;
    res.error        = er;
    res.queued_count = qc;
    return res;
  endfunction

  function automatic sched_outcome_t schedule_step(opcode_t op, logic [SLOT_W-1:0] s,
                                                   logic [PRIO_W-1:0] p);
    sched_outcome_t         res;
    logic [SLOT_W-1:0]      best;
    logic                   found;
    logic [STRIDE_BITS-1:0] gap;
    res = '0;
    case (op)
      OP_ENQUEUE: begin
        if (p == '0 || slot_queued[s]) begin
          res.error = 1'b1;
        end else begin
          slot_prio[s]   = p;
          slot_queued[s] = 1'b1;
          if (slot_slice[s] == '0 || slot_slice[s] > cur_max_slice) slot_slice[s] = cur_max_slice;
          queued_total++;
        end
      end
      OP_DEQUEUE: begin
        if (!slot_queued[s]) begin
          res.error = 1'b1;
        end else begin
          slot_queued[s] = 1'b0;
          queued_total--;
        end
      end
      OP_PICK: begin
        found = 1'b0;
        best  = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_queued[i]) begin
            // wrap-aware compare: a negative difference means a smaller pass
            gap = slot_stride[i] - slot_stride[best];
            if (!found || gap[STRIDE_BITS-1]) begin
              best  = SLOT_W'(i);
              found = 1'b1;
            end
          end
        end
        if (found) begin
          slot_stride[best] = slot_stride[best] + STRIDE_BITS'(cur_pass_numer / slot_prio[best]);
          res.picked_valid = 1'b1;
          res.picked_slot  = best;
        end
      end
      default: begin
        if (slot_slice[s] != '0) slot_slice[s]--;
        res.resched_req = (slot_slice[s] == '0);
      end
    endcase
    res.queued_count = queued_total;
    return res;
  endfunction

  function automatic logic [SLOT_W-1:0] find_slot(logic want_queued);
    int                base;
    logic [SLOT_W-1:0] s;
    base = $urandom_range(NUM_SLOTS - 1);
    for (int k = 0; k < NUM_SLOTS; k++) begin
      s = SLOT_W'((base + k) % NUM_SLOTS);
      if (slot_queued[s] == want_queued) return s;
    end
    return SLOT_W'(base);
  endfunction

  function automatic logic [PRIO_W-1:0] draw_priority();
    case ($urandom_range(3))
      0: return PRIO_W'($urandom_range(1, 4));
      1: return PRIO_W'($urandom_range(1, 65535));
      2: return $urandom_range(1) ? 16'hFFFF : 16'h0001;
      default: return PRIO_W'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic issue_op(opcode_t op, logic [SLOT_W-1:0] s, logic [PRIO_W-1:0] p,
                          logic typed, sched_outcome_t typed_outcome);
    sched_outcome_t predicted;
    while ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.slot         <= s;
    req_ch.priority_req <= p;
    do @(posedge clk); while (!req_ch.ready);
    predicted = schedule_step(op, s, p);
    pending_outcomes.push_back(typed ? typed_outcome : predicted);
  endtask

  task automatic issue_random_op();
    int                sel;
    opcode_t           op;
    logic [SLOT_W-1:0] s;
    logic [PRIO_W-1:0] p;
    sel = $urandom_range(99);
    s   = SLOT_W'($urandom_range(NUM_SLOTS - 1));
    p   = draw_priority();
    if (sel < 25) begin
      op = OP_ENQUEUE;
      if ($urandom_range(9) < 8) s = find_slot(1'b0);
      else if ($urandom_range(1)) p = '0;
    end else if (sel < 45) begin
      op = OP_DEQUEUE;
      if ($urandom_range(9) < 8) s = find_slot(1'b1);
    end else if (sel < 75) begin
      op = OP_PICK;
      p  = PRIO_W'($urandom_range(65535));
    end else begin
      op = OP_TICK;
      if ($urandom_range(1)) s = find_slot(1'b1);
    end
    issue_op(op, s, p, 1'b0, '0);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers go in back to back with valid held high
  task automatic set_config(logic [SLICE_W-1:0] slice_val, logic [DIVIDEND_W-1:0] stride_val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_MAX_SLICE;
    cfg_ch.data  <= CFG_DATA_W'(slice_val);
    do @(posedge clk); while (!cfg_ch.ready);
    cur_max_slice = slice_val;
    cfg_ch.index <= CFG_PASS_NUMER;
    cfg_ch.data  <= stride_val;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_pass_numer = stride_val;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic report_mismatch(string what, sched_outcome_t want, sched_outcome_t got);
    string exp_text;
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      exp_text = $sformatf("pv=%0d slot=%0d resched=%0d err=%0d cnt=%0d",
                           want.picked_valid, want.picked_slot, want.resched_req,
                           want.error, want.queued_count);
      $display("%0t %s: exp %s, got pv=%0d slot=%0d resched=%0d err=%0d cnt=%0d",
               $realtime, what, exp_text, got.picked_valid, got.picked_slot,
               got.resched_req, got.error, got.queued_count);
    end
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready) begin
      seen_outcome = outcome_of(rsp_ch.picked_valid, rsp_ch.picked_slot, rsp_ch.resched_req,
                                rsp_ch.error, rsp_ch.queued_count);
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result", '0, seen_outcome);
      end else begin
        want_outcome = pending_outcomes.pop_front();
        if (seen_outcome.picked_valid !== want_outcome.picked_valid ||
            seen_outcome.picked_slot  !== want_outcome.picked_slot  ||
            seen_outcome.resched_req  !== want_outcome.resched_req  ||
            seen_outcome.error        !== want_outcome.error        ||
            seen_outcome.queued_count !== want_outcome.queued_count)
          report_mismatch("result mismatch", want_outcome, seen_outcome);
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [SLICE_W-1:0]    phase_slice;
    logic [DIVIDEND_W-1:0] phase_stride;
    probe_row_t            row;

    mismatch_count = 0;
    req_idle_pct   = 0;
    rsp_stall_pct  = 0;
    rsp_hold_left  = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_queued[i] = 1'b0;
      slot_stride[i] = '0;
      slot_prio[i]   = '0;
      slot_slice[i]  = '0;
    end
    queued_total   = '0;
    cur_max_slice  = MAX_SLICE_RESET;
    cur_pass_numer = PASS_NUMER_RESET;

    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.opcode       <= OP_ENQUEUE;
    req_ch.slot         <= '0;
    req_ch.priority_req <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_MAX_SLICE;
    cfg_ch.data         <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, empty table, refusals, extremes, slice run-out
    directed_rows = '{
      '{OP_PICK,    6'd0,  16'h0000, 1'b1, outcome_of(1'b0, 6'd0, 1'b0, 1'b0, 7'd0)},
      '{OP_DEQUEUE, 6'd0,  16'h0000, 1'b1, outcome_of(1'b0, 6'd0, 1'b0, 1'b1, 7'd0)},
      '{OP_TICK,    6'd63, 16'h0000, 1'b1, outcome_of(1'b0, 6'd0, 1'b1, 1'b0, 7'd0)},
      '{OP_ENQUEUE, 6'd0,  16'h0000, 1'b1, outcome_of(1'b0, 6'd0, 1'b0, 1'b1, 7'd0)},
      '{OP_ENQUEUE, 6'd0,  16'hFFFF, 1'b1, outcome_of(1'b0, 6'd0, 1'b0, 1'b0, 7'd1)},
      '{OP_ENQUEUE, 6'd0,  16'h0001, 1'b1, outcome_of(1'b0, 6'd0, 1'b0, 1'b1, 7'd1)},
      '{OP_ENQUEUE, 6'd63, 16'h0001, 1'b1, outcome_of(1'b0, 6'd0, 1'b0, 1'b0, 7'd2)},
      '{OP_ENQUEUE, 6'd21, 16'hAAAA, 1'b1, outcome_of(1'b0, 6'd0, 1'b0, 1'b0, 7'd3)},
      '{OP_ENQUEUE, 6'd42, 16'h5555, 1'b1, outcome_of(1'b0, 6'd0, 1'b0, 1'b0, 7'd4)},
      '{OP_PICK,    6'd0,  16'h0000, 1'b1, outcome_of(1'b1, 6'd0, 1'b0, 1'b0, 7'd4)},
      '{OP_PICK,    6'd63, 16'hFFFF, 1'b0, '0},
      '{OP_PICK,    6'd21, 16'h0000, 1'b0, '0},
      '{OP_PICK,    6'd42, 16'h0000, 1'b0, '0},
      '{OP_TICK,    6'd63, 16'h0000, 1'b0, '0},
      '{OP_TICK,    6'd63, 16'h0000, 1'b0, '0},
      '{OP_TICK,    6'd63, 16'h0000, 1'b0, '0},
      '{OP_TICK,    6'd63, 16'h0000, 1'b0, '0},
      '{OP_TICK,    6'd63, 16'h0000, 1'b0, '0},
      '{OP_TICK,    6'd63, 16'h0000, 1'b0, '0},
      '{OP_DEQUEUE, 6'd63, 16'h0000, 1'b1, outcome_of(1'b0, 6'd0, 1'b0, 1'b0, 7'd3)},
      '{OP_ENQUEUE, 6'd63, 16'h0002, 1'b0, '0},
      '{OP_DEQUEUE, 6'd0,  16'h0000, 1'b0, '0},
      '{OP_DEQUEUE, 6'd21, 16'h0000, 1'b0, '0},
      '{OP_DEQUEUE, 6'd42, 16'h0000, 1'b0, '0},
      '{OP_DEQUEUE, 6'd63, 16'h0000, 1'b1, outcome_of(1'b0, 6'd0, 1'b0, 1'b0, 7'd0)},
      '{OP_PICK,    6'd63, 16'h0000, 1'b1, outcome_of(1'b0, 6'd0, 1'b0, 1'b0, 7'd0)}
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      issue_op(row.op, row.slot, row.prio, row.typed, row.outcome);
    end

    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin
          req_idle_pct = 0;  rsp_stall_pct = 0;
          phase_slice = 8'd1;   phase_stride = 31'd1;
        end
        1: begin
          req_idle_pct = 81; rsp_stall_pct = 0;
          phase_slice = 8'd255; phase_stride = 31'h4000_0000;
        end
        2: begin
          req_idle_pct = 0;  rsp_stall_pct = 81;
          phase_slice = SLICE_W'($urandom_range(2, 254));
          phase_stride = DIVIDEND_W'($urandom_range(1, 32'h4000_0000));
        end
        default: begin
          req_idle_pct = 33; rsp_stall_pct = 33;
          phase_slice = SLICE_W'($urandom_range(1, 8));
          phase_stride = DIVIDEND_W'($urandom_range(1, 65536));
        end
      endcase
      set_config(phase_slice, phase_stride);

      // fill every free slot so picks see a full table
      while (queued_total < NUM_SLOTS)
        issue_op(OP_ENQUEUE, find_slot(1'b0), draw_priority(), 1'b0, '0);

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 0 && n == 150) rsp_hold_left = 400;
        if (n == 200) begin
          drain_results();
        end
        issue_random_op();
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (PICK_LATENCY) @(posedge clk);

    if (mismatch_count == 0 && pending_outcomes.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
